// File: rtl/jdac_pkg.sv
// jdac_pkg: shared types and constants for the joystick debounce, average and classify block
// no dependencies; imported by jdac_classify and joystick_debounce_average_classify_core
`default_nettype none

package jdac_pkg;

  localparam int unsigned AdcW      = 12;
  localparam int unsigned CfgDataW  = 24;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned TickW     = 8;
  localparam int unsigned NumRanges = 5;

  typedef enum logic [2:0] {
    POS_NONE  = 3'd0,
    POS_UP    = 3'd1,
    POS_DOWN  = 3'd2,
    POS_LEFT  = 3'd3,
    POS_RIGHT = 3'd4,
    POS_ERROR = 3'd5
  } pos_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_NONE_RANGE    = 3'd0,
    CFG_UP_RANGE      = 3'd1,
    CFG_DOWN_RANGE    = 3'd2,
    CFG_LEFT_RANGE    = 3'd3,
    CFG_RIGHT_RANGE   = 3'd4,
    CFG_DEBOUNCE      = 3'd5,
    CFG_SAMPLE_PERIOD = 3'd6
  } cfg_idx_e;

  // upper bound in the high half, lower bound in the low half
  typedef struct packed {
    logic [AdcW-1:0] hi;
    logic [AdcW-1:0] lo;
  } range_t;

  typedef struct packed {
    logic            button_raw;
    logic [AdcW-1:0] adc_sample;
  } in_word_t;

  typedef struct packed {
    pos_e            position;
    logic            select_pressed;
    logic [AdcW-1:0] average_value;
  } out_word_t;

  localparam logic [CfgDataW-1:0] RST_NONE_RANGE  = 24'd16776226;
  localparam logic [CfgDataW-1:0] RST_UP_RANGE    = 24'd4014080;
  localparam logic [CfgDataW-1:0] RST_DOWN_RANGE  = 24'd11532541;
  localparam logic [CfgDataW-1:0] RST_LEFT_RANGE  = 24'd12720896;
  localparam logic [CfgDataW-1:0] RST_RIGHT_RANGE = 24'd9421781;
  localparam logic [TickW-1:0]    RST_DEBOUNCE    = 8'd50;
  localparam logic [TickW-1:0]    RST_PERIOD      = 8'd80;
  localparam logic [TickW-1:0]    TICK_MAX        = 8'd255;
  localparam logic [AdcW-1:0]     RST_SAMPLE      = 12'd3220;

endpackage

`default_nettype wire

// File: rtl/jdac_classify.sv
// jdac_classify: priority window compare of the average against the five position ranges
// depends on jdac_pkg
`default_nettype none

module jdac_classify
  import jdac_pkg::*;
(
  input  range_t [NumRanges-1:0] ranges_i,
  input  logic   [AdcW-1:0]      avg_i,
  output pos_e                   position_o
);

  // walk from the last range down so the lowest-numbered matching range wins
  always_comb begin
    position_o = POS_ERROR;
    for (int k = NumRanges - 1; k >= 0; k--) begin
      if ((avg_i >= ranges_i[k].lo) && (avg_i <= ranges_i[k].hi)) begin
        position_o = pos_e'(3'(k));
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/joystick_debounce_average_classify_core.sv
// joystick_debounce_average_classify_core: per-tick button debounce, ADC window average
// and position classification; depends on jdac_pkg and jdac_classify
// an accepted word updates the tick state, from which the classification is registered
// throughput: one word per cycle unless out_stall_i holds the output word
// reset: ranges, debounce and sample period take their defaults, the window holds the
// default sample, the first tick always samples, no output word is pending
`default_nettype none

module joystick_debounce_average_classify_core
  import jdac_pkg::*;
#(
  parameter int unsigned WINDOW_LEN  = 3,
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                clk_i,
  input  logic                rst_ni,

  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,

  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_word_t            in_data_i,

  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_word_t           out_data_o
);

  localparam int unsigned SW    = (SAMPLE_BITS < AdcW) ? SAMPLE_BITS : AdcW;
  localparam int unsigned PW    = $clog2(WINDOW_LEN);
  localparam int unsigned SUM_W = SW + PW;
  // exact reciprocal: sum * RECIP >> SHIFT == sum / WINDOW_LEN for every sum
  localparam int unsigned SHIFT = SUM_W + PW;
  localparam int unsigned RECIP = ((2 ** SHIFT) + WINDOW_LEN - 1) / WINDOW_LEN;
  localparam int unsigned PROD_W = SUM_W + SHIFT;
  localparam logic [SW-1:0] WIN_RST  = SW'(RST_SAMPLE);
  localparam logic [PW-1:0] POS_LAST = PW'(WINDOW_LEN - 1);

  // configuration
  range_t [NumRanges-1:0] range_q;
  logic   [TickW-1:0]     debounce_q;
  logic   [TickW-1:0]     period_q;

  // tick state
  logic                   last_raw_q, last_raw_d;
  logic                   stable_q, stable_d;
  logic   [TickW-1:0]     tsc_q, tsc_d;
  logic   [TickW-1:0]     tss_q, tss_d;
  logic   [SW-1:0]        window_q [WINDOW_LEN];
  logic   [PW-1:0]        wpos_q, wpos_d;
  logic   [SW-1:0]        avg_q, avg_d;

  // flow control
  logic                   s1_valid_q, s1_valid_d;
  logic                   out_valid_q, out_valid_d;
  out_word_t              out_data_q;
  logic                   out_load;
  logic                   accept;

  logic   [TickW-1:0]     elapsed;
  logic                   take_sample;
  logic   [SW-1:0]        sample;
  logic   [SUM_W-1:0]     sum;
  logic   [PROD_W-1:0]    prod;
  pos_e                   position;

  assign cfg_ready_o = 1'b1;

  assign out_load   = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !out_load;
  assign accept     = in_valid_i && !in_stall_o;

  assign s1_valid_d  = accept || (s1_valid_q && !out_load);
  assign out_valid_d = out_load ? s1_valid_q : out_valid_q;

  assign sample = SW'(in_data_i.adc_sample);

  always_comb begin
    last_raw_d = in_data_i.button_raw;
    if (in_data_i.button_raw != last_raw_q) begin
      tsc_d = '0;
    end else if (tsc_q != TICK_MAX) begin
      tsc_d = tsc_q + 1'b1;
    end else begin
      tsc_d = tsc_q;
    end
    stable_d = (tsc_d > debounce_q) ? in_data_i.button_raw : stable_q;

    elapsed     = (tss_q != TICK_MAX) ? tss_q + 1'b1 : tss_q;
    take_sample = (elapsed >= period_q);
    tss_d       = take_sample ? '0 : elapsed;
    wpos_d      = (wpos_q == POS_LAST) ? '0 : wpos_q + 1'b1;
  end

  // sum of the window as it stands after the new sample is written
  always_comb begin
    sum = '0;
    for (int i = 0; i < WINDOW_LEN; i++) begin
      if (PW'(i) == wpos_q) begin
        sum = sum + SUM_W'(sample);
      end else begin
        sum = sum + SUM_W'(window_q[i]);
      end
    end
    prod  = PROD_W'(sum) * PROD_W'(RECIP);
    avg_d = SW'(prod >> SHIFT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_q[CFG_NONE_RANGE]  <= RST_NONE_RANGE;
      range_q[CFG_UP_RANGE]    <= RST_UP_RANGE;
      range_q[CFG_DOWN_RANGE]  <= RST_DOWN_RANGE;
      range_q[CFG_LEFT_RANGE]  <= RST_LEFT_RANGE;
      range_q[CFG_RIGHT_RANGE] <= RST_RIGHT_RANGE;
      debounce_q               <= RST_DEBOUNCE;
      period_q                 <= RST_PERIOD;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_NONE_RANGE, CFG_UP_RANGE, CFG_DOWN_RANGE, CFG_LEFT_RANGE,
        CFG_RIGHT_RANGE: begin
          range_q[cfg_index_i] <= cfg_data_i;
        end
        CFG_DEBOUNCE:      debounce_q <= cfg_data_i[TickW-1:0];
        CFG_SAMPLE_PERIOD: period_q   <= cfg_data_i[TickW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_raw_q <= 1'b1;
      stable_q   <= 1'b1;
      tsc_q      <= '0;
      tss_q      <= TICK_MAX;
      wpos_q     <= '0;
      avg_q      <= WIN_RST;
      for (int i = 0; i < WINDOW_LEN; i++) begin
        window_q[i] <= WIN_RST;
      end
    end else if (accept) begin
      last_raw_q <= last_raw_d;
      stable_q   <= stable_d;
      tsc_q      <= tsc_d;
      tss_q      <= tss_d;
      if (take_sample) begin
        window_q[wpos_q] <= sample;
        wpos_q           <= wpos_d;
        avg_q            <= avg_d;
      end
    end
  end

  // the tick state only moves on accept, so it doubles as the stage one word
  jdac_classify u_classify (
    .ranges_i   (range_q),
    .avg_i      (AdcW'(avg_q)),
    .position_o (position)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load && s1_valid_q) begin
      out_data_q.position       <= position;
      out_data_q.select_pressed <= !stable_q;
      out_data_q.average_value  <= AdcW'(avg_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire
